// ----- hdl/rpa_pkg.sv -----
// Shared widths, codes and state type for the refcounted page allocator.
`timescale 1ns / 1ps

package rpa_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 34;
    localparam int OP_W       = 3;
    localparam int RC_W       = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 40;   // page_address padded to bytes
    localparam int IN_USER_W  = 8;    // operation padded to a byte
    localparam int OUT_DATA_W = 48;   // alloc_address, ref_count, page_freed, status

    // Configuration register reset values
    localparam logic [ADDR_W-1:0] BASE_RESET = 34'h080000000;
    localparam logic [ADDR_W-1:0] TOP_RESET  = 34'h088000000;
    localparam logic [ADDR_W-1:0] FFA_RESET  = 34'h080000000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FFA  = 2'd2;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_RELEASE = 3'd2,
        OP_ADD     = 3'd3,
        OP_DROP    = 3'd4,
        OP_READ    = 3'd5
    } op_t;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_MEM    = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_ZERO      = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_INIT_SETUP,
        S_INIT_WALK
    } state_t;

endpackage

// ----- hdl/refcounted_page_allocator.sv -----
// Refcounted page allocator: sequencer, config registers and two RAMs.
// Alloc, release, add, drop and read: the accept cycle reads the count and stack RAMs,
// and the exec state then modifies and writes back, waiting there while the result
// register is full. A new request is taken only once the sequencer is back in idle.
// Init runs a setup state, then a walk that pushes one page per cycle onto the stack.
// Reset: synchronous, active low; a clearing pass then zeroes every entry of the count
// RAM, during which no request is accepted (configuration writes still are).
`timescale 1ns / 1ps

module refcounted_page_allocator #(
    parameter int PAGES      = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpa_pkg::ADDR_W-1:0]      cfg_wdata,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rpa_pkg::IN_DATA_W-1:0]   s_tdata,   // [33:0] page_address
    input  logic [rpa_pkg::IN_USER_W-1:0]   s_tuser,   // [2:0] operation
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rpa_pkg::OUT_DATA_W-1:0]  m_tdata    // [33:0] alloc_address,
                                                       // [41:34] ref_count,
                                                       // [42] page_freed,
                                                       // [45:43] status
);

    import rpa_pkg::*;

    localparam int IDX_W = $clog2(PAGES);
    localparam int TOP_W = $clog2(PAGES + 1);
    localparam int BN_W  = ADDR_W - PAGE_SHIFT;
    localparam int PN_W  = BN_W + 1;
    localparam int CW    = (COUNT_BITS > RC_W) ? COUNT_BITS : RC_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [IDX_W-1:0]      CLR_LAST = IDX_W'(PAGES - 1);
    localparam logic [TOP_W-1:0]      TOP_FULL = TOP_W'(PAGES);

    // State and registers
    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       base_reg, top_reg, ffa_reg;
    logic [OP_W-1:0]         op_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [TOP_W-1:0]        free_top_reg, free_top_next;
    logic [PN_W-1:0]         pnum_reg, pnum_next;
    logic [IDX_W-1:0]        clr_reg, clr_next;
    logic                    m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]       alloc_reg, alloc_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                    freed_reg, freed_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    // RAM ports
    logic                    cnt_we;
    logic [IDX_W-1:0]        cnt_waddr;
    logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rdata;
    logic                    stk_we;
    logic [IDX_W-1:0]        stk_waddr;
    logic [IDX_W-1:0]        stk_wdata, stk_rdata;

    // Handshake
    logic in_acc, out_free, load_out;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Page numbers and request index
    logic [BN_W-1:0]   bn, in_pn;
    logic [ADDR_W-1:0] in_addr;
    logic [IDX_W-1:0]  in_idx;
    logic [TOP_W-1:0]  top_dec;
    assign bn      = base_reg[ADDR_W-1:PAGE_SHIFT];
    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_pn   = in_addr[ADDR_W-1:PAGE_SHIFT];
    assign in_idx  = IDX_W'(in_pn) - IDX_W'(bn);
    assign top_dec = free_top_reg - 1'b1;

    // Address check on the held request
    logic [BN_W-1:0] req_diff;
    logic            addr_ok;
    assign req_diff = addr_reg[ADDR_W-1:PAGE_SHIFT] - bn;
    assign addr_ok  = (addr_reg[PAGE_SHIFT-1:0] == '0) && (addr_reg >= ffa_reg)
                   && (addr_reg >= base_reg) && (addr_reg < top_reg)
                   && (64'(req_diff) < 64'(PAGES));

    // Init start page and walk condition
    logic [PN_W-1:0] pf, pb, top_pn, walk_diff;
    logic            walk_go;
    assign pf = PN_W'(ffa_reg[ADDR_W-1:PAGE_SHIFT])
              + PN_W'(ffa_reg[PAGE_SHIFT-1:0] != '0);
    assign pb = PN_W'(bn) + PN_W'(base_reg[PAGE_SHIFT-1:0] != '0);
    assign top_pn    = PN_W'(top_reg[ADDR_W-1:PAGE_SHIFT]);
    assign walk_diff = pnum_reg - PN_W'(bn);
    assign walk_go   = (pnum_reg < top_pn) && (64'(walk_diff) < 64'(PAGES));

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    state_next = (s_tuser[OP_W-1:0] == OP_INIT) ? S_INIT_SETUP : S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) state_next = S_IDLE;
            end
            S_INIT_SETUP: state_next = S_INIT_WALK;
            S_INIT_WALK: begin
                if (!walk_go && out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        logic [COUNT_BITS-1:0] dec_cnt;
        dec_cnt       = cnt_rdata - 1'b1;
        cnt_we        = 1'b0;
        cnt_waddr     = idx_reg;
        cnt_wdata     = CNT_ZERO;
        stk_we        = 1'b0;
        stk_waddr     = free_top_reg[IDX_W-1:0];
        stk_wdata     = idx_reg;
        free_top_next = free_top_reg;
        pnum_next     = pnum_reg;
        clr_next      = clr_reg;
        load_out      = 1'b0;
        alloc_next    = '0;
        cnt_next      = CNT_ZERO;
        freed_next    = 1'b0;
        status_next   = ST_OK;
        unique case (state_reg)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            S_IDLE: ;
            S_EXEC: begin
                load_out = out_free;
                unique case (op_reg)
                    OP_ALLOC: begin
                        if (free_top_reg == '0) begin
                            status_next = ST_NO_MEM;
                        end else begin
                            free_top_next = top_dec;
                            cnt_we        = out_free;
                            cnt_waddr     = stk_rdata;
                            cnt_wdata     = CNT_ONE;
                            cnt_next      = CNT_ONE;
                            alloc_next    = {bn + BN_W'(stk_rdata), {PAGE_SHIFT{1'b0}}};
                        end
                    end
                    OP_RELEASE, OP_DROP: begin
                        if (!addr_ok) begin
                            status_next = ST_BAD_ADDR;
                        end else if (cnt_rdata == CNT_ZERO) begin
                            status_next = ST_ZERO;
                        end else begin
                            cnt_we    = out_free;
                            cnt_wdata = dec_cnt;
                            cnt_next  = dec_cnt;
                            if (op_reg == OP_RELEASE && dec_cnt == CNT_ZERO) begin
                                freed_next = 1'b1;
                                if (free_top_reg < TOP_FULL) begin
                                    stk_we        = out_free;
                                    free_top_next = free_top_reg + 1'b1;
                                end
                            end
                        end
                    end
                    OP_ADD: begin
                        if (!addr_ok) begin
                            status_next = ST_BAD_ADDR;
                        end else if (cnt_rdata == CNT_MAX) begin
                            status_next = ST_SATURATED;
                            cnt_next    = cnt_rdata;
                        end else begin
                            cnt_we    = out_free;
                            cnt_wdata = cnt_rdata + 1'b1;
                            cnt_next  = cnt_rdata + 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (!addr_ok) status_next = ST_BAD_ADDR;
                        else          cnt_next    = cnt_rdata;
                    end
                    default: ;
                endcase
                // hold stack pointer while the result register is busy
                if (!out_free) free_top_next = free_top_reg;
            end
            S_INIT_SETUP: begin
                free_top_next = '0;
                pnum_next     = (pf > pb) ? pf : pb;
            end
            S_INIT_WALK: begin
                if (walk_go) begin
                    cnt_we        = 1'b1;
                    cnt_waddr     = IDX_W'(walk_diff);
                    stk_we        = 1'b1;
                    stk_wdata     = IDX_W'(walk_diff);
                    free_top_next = free_top_reg + 1'b1;
                    pnum_next     = pnum_reg + 1'b1;
                end else begin
                    load_out = out_free;
                end
            end
            default: ;
        endcase
    end

    assign m_valid_next = load_out || (m_valid_reg && !m_tready);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            free_top_reg <= '0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            free_top_reg <= free_top_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
            top_reg  <= TOP_RESET;
            ffa_reg  <= FFA_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BASE: base_reg <= cfg_wdata;
                CFG_TOP:  top_reg  <= cfg_wdata;
                CFG_FFA:  ffa_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Request and walk payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            op_reg   <= s_tuser[OP_W-1:0];
            addr_reg <= in_addr;
            idx_reg  <= in_idx;
        end
        pnum_reg <= pnum_next;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            alloc_reg  <= alloc_next;
            cnt_reg    <= cnt_next;
            freed_reg  <= freed_next;
            status_reg <= status_next;
        end
    end

    logic [CW-1:0] cnt_wide;
    assign cnt_wide = CW'(cnt_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, status_reg, freed_reg, cnt_wide[RC_W-1:0], alloc_reg};

    // Reference count RAM
    rpa_ram #(
        .DEPTH (PAGES),
        .WIDTH (COUNT_BITS)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (in_acc),
        .raddr (in_idx),
        .rdata (cnt_rdata)
    );

    // Free stack RAM
    rpa_ram #(
        .DEPTH (PAGES),
        .WIDTH (IDX_W)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (in_acc),
        .raddr (top_dec[IDX_W-1:0]),
        .rdata (stk_rdata)
    );

endmodule

// ----- hdl/rpa_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module rpa_ram #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the refcounted page allocator.
`timescale 1ns / 1ps

module testbench;
    import rpa_pkg::*;

    localparam int PAGES       = 32768;
    localparam int PAGE_SHIFT  = 12;
    localparam int COUNT_BITS  = 8;
    localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
    localparam int IDX_W       = $clog2(PAGES);
    localparam int QUIET_LIMIT = 150000;

    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;

    // codes with no operation: the block answers them with an empty OK result
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // one result as the block should report it, plus the request behind it
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] alloc_addr;
        logic [RC_W-1:0]   count;
        logic              freed;
        status_t           status;
    } alloc_result_t;

    // Page table model: counts, free stack and registers, plus pending results
    class alloc_scoreboard;
        bit [COUNT_BITS-1:0] counts [PAGES];
        bit [IDX_W-1:0]      free_pages [PAGES];
        int unsigned         free_depth;
        logic [ADDR_W-1:0]   reg_base;
        logic [ADDR_W-1:0]   reg_top;
        logic [ADDR_W-1:0]   reg_ffa;
        alloc_result_t       pending_results [$];
        int                  errors;

        function new();
            reg_base   = BASE_RESET;
            reg_top    = TOP_RESET;
            reg_ffa    = FFA_RESET;
            free_depth = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            case (idx)
                CFG_BASE: reg_base = value;
                CFG_TOP:  reg_top  = value;
                CFG_FFA:  reg_ffa  = value;
                default: ;
            endcase
        endfunction

        // aligned, inside [max(ffa, base), top) and within the table
        function bit page_index(longint unsigned a, output int unsigned idx);
            longint unsigned pn;
            longint unsigned bn;
            idx = 0;
            if ((a & (longint'(PAGE_BYTES) - 1)) != 0) return 1'b0;
            if (a < reg_ffa || a < reg_base || a >= reg_top) return 1'b0;
            pn = a >> PAGE_SHIFT;
            bn = longint'(reg_base) >> PAGE_SHIFT;
            if (pn - bn >= PAGES) return 1'b0;
            idx = int'(pn - bn);
            return 1'b1;
        endfunction

        function void push_free(int unsigned idx);
            if (free_depth < PAGES) begin
                free_pages[free_depth] = IDX_W'(idx);
                free_depth++;
            end
        endfunction

        // init: empty the stack, then push every whole page in range, lowest first
        function void refill();
            longint unsigned step;
            longint unsigned mask;
            longint unsigned p;
            longint unsigned b;
            int unsigned idx;
            step = longint'(PAGE_BYTES);
            mask = step - 1;
            p = (longint'(reg_ffa) + mask) & ~mask;
            b = (longint'(reg_base) + mask) & ~mask;
            free_depth = 0;
            if (p < b) p = b;
            while (p + step <= reg_top) begin
                if (!page_index(p, idx)) break;
                counts[idx] = '0;
                push_free(idx);
                p += step;
            end
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
            alloc_result_t r;
            int unsigned idx;
            int unsigned cnt;
            longint unsigned page_no;
            r.op = op;
            r.addr = addr;
            r.alloc_addr = '0;
            r.count = '0;
            r.freed = 1'b0;
            r.status = ST_OK;
            cnt = 0;
            case (op)
                OP_INIT: refill();
                OP_ALLOC: begin
                    if (free_depth == 0) begin
                        r.status = ST_NO_MEM;
                    end else begin
                        free_depth--;
                        idx = 32'(free_pages[free_depth]);
                        counts[idx] = COUNT_BITS'(1);
                        r.count = RC_W'(1);
                        page_no = (longint'(reg_base) >> PAGE_SHIFT) + idx;
                        r.alloc_addr = ADDR_W'(page_no << PAGE_SHIFT);
                    end
                end
                OP_RELEASE, OP_ADD, OP_DROP, OP_READ: begin
                    if (!page_index(64'(addr), idx)) begin
                        r.status = ST_BAD_ADDR;
                    end else begin
                        cnt = 32'(counts[idx]);
                        if (op == OP_RELEASE || op == OP_DROP) begin
                            if (cnt == 0) begin
                                r.status = ST_ZERO;
                            end else begin
                                cnt--;
                                counts[idx] = COUNT_BITS'(cnt);
                                // only a release hands the page back
                                if (op == OP_RELEASE && cnt == 0) begin
                                    push_free(idx);
                                    r.freed = 1'b1;
                                end
                            end
                        end else if (op == OP_ADD) begin
                            if (cnt >= COUNT_MAX) begin
                                r.status = ST_SATURATED;
                            end else begin
                                cnt++;
                                counts[idx] = COUNT_BITS'(cnt);
                            end
                        end
                        r.count = RC_W'(cnt);
                    end
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, alloc_result_t e,
                                    logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch (op %0d addr %h): expected %h actual %h",
                         $time, field, e.op, e.addr, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            alloc_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %h", $time, d);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            compare_field("alloc_address", e, 64'(e.alloc_addr), 64'(d[33:0]));
            compare_field("ref_count", e, 64'(e.count), 64'(d[41:34]));
            compare_field("page_freed", e, 64'(e.freed), 64'(d[42]));
            compare_field("status", e, 64'(e.status), 64'(d[45:43]));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;   // [33:0] page_address
    logic [IN_USER_W-1:0]   s_tuser   = '0;   // [2:0] operation
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // [33:0] alloc_address, [41:34] ref_count,
                                              // [42] page_freed, [45:43] status

    alloc_scoreboard sb = new();
    int steady_left = 0;
    int quiet_cycles = 0;

    refcounted_page_allocator #(
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request; called at a clock edge, returns at the edge that took it
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = (steady_left > 0) ? 0 : pick_gap();
        if (steady_left > 0) steady_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {{(IN_USER_W - OP_W){1'b0}}, op};
        s_tdata  <= {{(IN_DATA_W - ADDR_W){1'b0}}, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, addr);
    endtask

    // drop valid and let every outstanding result come back, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    // New memory map while idle, followed by an init of the free stack
    task automatic configure(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top,
                             input logic [ADDR_W-1:0] ffa);
        wait_drained();
        put_reg(CFG_BASE, base);
        put_reg(CFG_TOP, top);
        put_reg(CFG_FFA, ffa);
        cfg_we <= 1'b0;
        send_request(OP_INIT, {2'($urandom_range(0, 3)), 32'($urandom)});
    endtask

    // Mostly well-formed traffic on a window of pages around the managed range
    task automatic random_traffic(input int count, input logic [ADDR_W-1:0] win_lo,
                                  input int win_n, input bit allow_init);
        int pick;
        logic [ADDR_W-1:0] page;
        logic [OP_W-1:0] op;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) steady_left = ($urandom_range(0, 2) == 0) ? 40 : 0;
            pick = $urandom_range(0, 99);
            page = win_lo + (ADDR_W'($urandom_range(0, win_n - 1)) << PAGE_SHIFT);
            if (pick < 24) begin
                op = OP_ALLOC;
            end else if (pick < 44) begin
                op = OP_RELEASE;
            end else if (pick < 58) begin
                op = OP_ADD;
            end else if (pick < 72) begin
                op = OP_DROP;
            end else if (pick < 82) begin
                op = OP_READ;
            end else if (pick < 84) begin
                op = allow_init ? OP_INIT : OP_READ;
            end else if (pick < 92) begin
                // near miss: right page, wrong alignment
                case ($urandom_range(0, 3))
                    0:       op = OP_RELEASE;
                    1:       op = OP_ADD;
                    2:       op = OP_DROP;
                    default: op = OP_READ;
                endcase
                page = page + ADDR_W'($urandom_range(1, int'(PAGE_BYTES) - 1));
            end else begin
                // noise: any code (init only if allowed), any address
                op = OP_W'($urandom_range(allow_init ? OP_INIT : OP_ALLOC, OP_SPARE_B));
                page = {2'($urandom_range(0, 3)), 32'($urandom)};
            end
            send_request(op, page);
        end
    endtask

    // Stimulus
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset map, stack still empty
        send_request(OP_ALLOC, '0);
        send_request(OP_READ, BASE_RESET);
        send_request(OP_RELEASE, BASE_RESET);
        send_request(OP_DROP, BASE_RESET);
        send_request(OP_ADD, BASE_RESET);
        send_request(OP_READ, BASE_RESET + 1);
        send_request(OP_READ, BASE_RESET - PAGE_BYTES);
        send_request(OP_READ, TOP_RESET);
        send_request(OP_READ, TOP_RESET - PAGE_BYTES);
        send_request(OP_ADD, '0);
        send_request(OP_DROP, '1);
        send_request(OP_ADD, 34'h3FFFFF000);
        send_request(OP_SPARE_A, '1);
        send_request(OP_SPARE_B, BASE_RESET);
        // full range: every tracked page goes on the stack
        send_request(OP_INIT, '0);
        send_request(OP_ADD, BASE_RESET);
        send_request(OP_RELEASE, BASE_RESET);    // freed into a full stack
        send_request(OP_ALLOC, '0);              // highest page first
        send_request(OP_DROP, TOP_RESET - PAGE_BYTES);
        send_request(OP_RELEASE, TOP_RESET - PAGE_BYTES);
        send_request(OP_ALLOC, '0);
        send_request(OP_RELEASE, TOP_RESET - 2 * PAGE_BYTES);
        send_request(OP_ALLOC, '0);              // same page comes back

        // small range above a reserved low part; drive one page to saturation
        configure(34'h080000000, 34'h080010000, 34'h080004000);
        repeat (COUNT_MAX + 2) send_request(OP_ADD, 34'h080008000);
        random_traffic(140, 34'h080003000, 14, 1'b1);

        // unaligned base, first free address below it
        configure(34'h100000800, 34'h100020000, 34'h000000000);
        random_traffic(130, 34'h100000000, 34, 1'b1);

        // widest map: base zero, top at the end of the address space
        configure(34'h000000000, 34'h3FFFFFFFF, 34'h000000000);
        random_traffic(100, 34'h007FF0000, 18, 1'b0);

        // pages at the very top of the address space
        configure(34'h3FFFF0000, 34'h3FFFFFFFF, 34'h3FFFF8000);
        random_traffic(100, 34'h3FFFF6000, 10, 1'b1);

        // empty map: top below base, nothing ever valid
        configure(34'h3FFFFFFFF, 34'h000000000, 34'h3FFFFFFFF);
        random_traffic(45, 34'h3FFFFC000, 4, 1'b1);

        wait_drained();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: random back-pressure, two long hold-offs to fill the block
    initial begin
        int stall;
        int run;
        int seen;
        stall = 0;
        run = 0;
        seen = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                seen++;
                if (seen == 300 || seen == 650) begin
                    stall = 250;
                    run = 0;
                end
            end
            if (stall == 0 && run == 0) begin
                stall = pick_gap();
                run = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                run--;
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, sb.outstanding());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ----- refcounted_page_allocator.f -----
hdl/rpa_pkg.sv
hdl/rpa_ram.sv
hdl/refcounted_page_allocator.sv
verif/testbench.sv
